>>> sv/bnse_pkg.sv
`timescale 1ns / 1ps
package bnse_pkg;

  localparam int GROUP_W     = 40;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] MODE_B64    = 3'd0;
  localparam logic [2:0] MODE_B64URL = 3'd1;
  localparam logic [2:0] MODE_B32    = 3'd2;
  localparam logic [2:0] MODE_B32HEX = 3'd3;
  localparam logic [2:0] MODE_B16    = 3'd4;

  localparam logic CFG_ALPHABET = 1'b0;
  localparam logic CFG_PADDING  = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [GROUP_W-1:0] bits;     // left aligned, first char in the top bits
    logic [2:0]         mode;
    logic [3:0]         data_cnt; // alphabet characters
    logic [3:0]         total;    // alphabet plus pad characters
    logic               last;
  } bnse_job_t;

  typedef struct packed {
    logic [2:0] grp_bytes;
    logic [3:0] out_chars;
    logic [2:0] char_bits;
  } bnse_geom_t;

  function automatic bnse_geom_t bnse_geom(input logic [2:0] mode);
    bnse_geom_t g;
    case (mode)
      MODE_B64, MODE_B64URL: g = '{grp_bytes: 3'd3, out_chars: 4'd4, char_bits: 3'd6};
      MODE_B32, MODE_B32HEX: g = '{grp_bytes: 3'd5, out_chars: 4'd8, char_bits: 3'd5};
      default:               g = '{grp_bytes: 3'd1, out_chars: 4'd2, char_bits: 3'd4};
    endcase
    return g;
  endfunction

  // characters for a partial group of n bytes: ceil(8n / char_bits)
  function automatic logic [3:0] bnse_part_chars(input logic [2:0] mode,
                                                 input logic [2:0] n);
    logic [3:0] c;
    c = 4'd2;
    case (mode)
      MODE_B64, MODE_B64URL: c = (n == 3'd2) ? 4'd3 : 4'd2;
      MODE_B32, MODE_B32HEX: begin
        case (n)
          3'd2:    c = 4'd4;
          3'd3:    c = 4'd5;
          3'd4:    c = 4'd7;
          default: c = 4'd2;
        endcase
      end
      default: c = 4'd2;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] bnse_char(input logic [2:0] mode, input logic [5:0] idx);
    logic [7:0] c;
    case (mode)
      MODE_B64, MODE_B64URL: begin
        if (idx < 6'd26)      c = 8'h41 + {2'b00, idx};
        else if (idx < 6'd52) c = 8'h61 + {2'b00, idx} - 8'd26;
        else if (idx < 6'd62) c = 8'h30 + {2'b00, idx} - 8'd52;
        else if (idx == 6'd62) c = (mode == MODE_B64) ? 8'h2B : 8'h2D;
        else                  c = (mode == MODE_B64) ? 8'h2F : 8'h5F;
      end
      MODE_B32: begin
        if (idx < 6'd26) c = 8'h41 + {2'b00, idx};
        else             c = 8'h32 + {2'b00, idx} - 8'd26;
      end
      default: begin
        if (idx < 6'd10) c = 8'h30 + {2'b00, idx};
        else             c = 8'h41 + {2'b00, idx} - 8'd10;
      end
    endcase
    return c;
  endfunction

endpackage

>>> sv/base_n_stream_encoder_core.sv
`timescale 1ns / 1ps
// Base64 / base32 / base16 stream encoder. Bytes enter on the in_ stream, one per
// transfer, with in_tlast on the final byte of a message; characters leave on the
// out_ stream, one per transfer, with out_tlast on the final character. A byte is
// taken every cycle while the job queue has room; the output side delivers one
// character per cycle while out_tready is high, so the sustained rate is set by
// the character serializer: base64 gives four characters per three bytes,
// base32 eight per five, base16 two per byte. Write alphabet_mode (index 0)
// and padding_enable (index 1) on the cfg_ port only while the block is idle.
module base_n_stream_encoder_core
  import bnse_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [2:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_char
  output logic       out_tlast
);

  logic      q_full, q_push, q_pop, q_avail;
  bnse_job_t push_job, pop_job;

  bnse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  bnse_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_job  (pop_job)
  );

  bnse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_avail    (q_avail),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sv/bnse_front.sv
`timescale 1ns / 1ps
module bnse_front
  import bnse_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_addr,
  input  logic [2:0]      cfg_wdata,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tlast,
  input  logic            q_full,
  output logic            q_push,
  output bnse_job_t       q_job
);

  logic [2:0]         mode_r;
  logic               pad_r;
  logic [GROUP_W-1:0] bits_r, bits_nxt;
  logic [2:0]         cnt_r, cnt_nxt;

  logic               accept;
  logic [GROUP_W-1:0] new_bits;
  logic [2:0]         n;
  logic               full;
  logic [2:0]         used;
  bnse_geom_t         geom;
  logic [3:0]         part;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign geom      = bnse_geom(mode_r);
  assign new_bits  = {bits_r[GROUP_W-9:0], in_tdata};
  assign n         = cnt_r + 3'd1;
  assign full      = (n == 3'd0) || (n >= geom.grp_bytes);
  assign used      = full ? geom.grp_bytes : n;
  assign part      = bnse_part_chars(mode_r, n);

  always_comb begin
    q_job.mode     = mode_r;
    q_job.last     = in_tlast;
    q_job.data_cnt = full ? geom.out_chars : part;
    q_job.total    = (full || pad_r) ? geom.out_chars : part;
    case (used)
      3'd1:    q_job.bits = {new_bits[7:0], 32'h0};
      3'd2:    q_job.bits = {new_bits[15:0], 24'h0};
      3'd3:    q_job.bits = {new_bits[23:0], 16'h0};
      3'd4:    q_job.bits = {new_bits[31:0], 8'h0};
      default: q_job.bits = new_bits;
    endcase
    q_push   = accept && (full || in_tlast);
    bits_nxt = bits_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (full || in_tlast) begin
        bits_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        bits_nxt = new_bits;
        cnt_nxt  = n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_B64;
      pad_r  <= 1'b1;
      bits_r <= '0;
      cnt_r  <= '0;
    end else begin
      bits_r <= bits_nxt;
      cnt_r  <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ALPHABET: mode_r <= cfg_wdata;
          CFG_PADDING:  pad_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> sv/bnse_queue.sv
`timescale 1ns / 1ps
module bnse_queue
  import bnse_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  bnse_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      avail,
  output bnse_job_t pop_job
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bnse_job_t       mem [DEPTH];
  logic [AW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;

  assign full    = (cnt_r == CW'(DEPTH));
  assign avail   = (cnt_r != '0);
  assign pop_job = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> sv/bnse_back.sv
`timescale 1ns / 1ps
module bnse_back
  import bnse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_avail,
  input  bnse_job_t  q_job,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic               busy_r;
  logic [GROUP_W-1:0] sh_r;
  logic [2:0]         mode_r;
  logic [3:0]         data_r;
  logic [3:0]         rem_r;
  logic               last_r;
  logic               ovalid_r;
  logic [7:0]         ochar_r;
  logic               olast_r;

  logic               adv;
  logic               finishing;
  bnse_geom_t         geom;
  logic [5:0]         idx;

  assign geom      = bnse_geom(mode_r);
  assign adv       = !ovalid_r || out_tready;
  assign finishing = busy_r && (rem_r == 4'd1);
  assign q_pop     = adv && q_avail && (!busy_r || finishing);

  always_comb begin
    case (geom.char_bits)
      3'd6:    idx = sh_r[GROUP_W-1 -: 6];
      3'd5:    idx = {1'b0, sh_r[GROUP_W-1 -: 5]};
      default: idx = {2'b00, sh_r[GROUP_W-1 -: 4]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else if (adv) begin
      ovalid_r <= busy_r;
      if (busy_r) begin
        ochar_r <= (data_r != 4'd0) ? bnse_char(mode_r, idx) : PAD_CHAR;
        olast_r <= last_r && finishing;
      end
      if (q_pop) begin
        busy_r <= 1'b1;
        sh_r   <= q_job.bits;
        mode_r <= q_job.mode;
        data_r <= q_job.data_cnt;
        rem_r  <= q_job.total;
        last_r <= q_job.last;
      end else if (busy_r) begin
        case (geom.char_bits)
          3'd6:    sh_r <= {sh_r[GROUP_W-7:0], 6'h0};
          3'd5:    sh_r <= {sh_r[GROUP_W-6:0], 5'h0};
          default: sh_r <= {sh_r[GROUP_W-5:0], 4'h0};
        endcase
        if (data_r != 4'd0) begin
          data_r <= data_r - 4'd1;
        end
        rem_r <= rem_r - 4'd1;
        if (finishing) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import bnse_pkg::*;

  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       lst;
  } msg_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_addr = 1'b0;
  logic [2:0] cfg_wdata = 3'd0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  string b64_std = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  string b64_url = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
  string b32_std = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
  string b32_hex = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
  string b16_hex = "0123456789ABCDEF";

  msg_byte_t pending_q[$];
  enc_char_t char_q[$];

  // encoder state mirror
  logic [39:0] grp_bits = 40'd0;
  logic [2:0]  grp_cnt = 3'd0;
  logic [2:0]  enc_mode = MODE_B64;
  logic        enc_pad = 1'b1;

  msg_byte_t   drv_item;
  int          burst_left = 1;
  int          gap_left = 0;
  enc_char_t   want;
  int          mismatches = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  logic [5:0]  stall_phase = 6'd0;
  int          quiet = 0;

  base_n_stream_encoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // data_byte
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // out_char
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] symbol(input logic [2:0] mode, input int idx);
    case (mode)
      MODE_B64:    return b64_std[idx];
      MODE_B64URL: return b64_url[idx];
      MODE_B32:    return b32_std[idx];
      MODE_B32HEX: return b32_hex[idx];
      default:     return b16_hex[idx];
    endcase
  endfunction

  task automatic encode_byte(input logic [7:0] b, input logic lst);
    int ig, og, ob, n, nch, total, k;
    logic [63:0] v;
    bit full;
    enc_char_t c;
    case (enc_mode)
      MODE_B64, MODE_B64URL: begin
        ig = 3; og = 4; ob = 6;
      end
      MODE_B32, MODE_B32HEX: begin
        ig = 5; og = 8; ob = 5;
      end
      default: begin
        ig = 1; og = 2; ob = 4;
      end
    endcase
    grp_bits = {grp_bits[31:0], b};
    grp_cnt = grp_cnt + 3'd1;
    n = int'(grp_cnt);
    full = (n == 0) || (n >= ig);
    if (full || lst) begin
      v = {24'd0, grp_bits} & ((64'd1 << (8 * ig)) - 64'd1);
      if (full) begin
        nch = og;
      end else begin
        v = v << (8 * (ig - n));
        nch = (8 * n + ob - 1) / ob;
      end
      total = (!full && enc_pad) ? og : nch;
      for (k = 0; k < total; k++) begin
        if (k < nch)
          c.ch = symbol(enc_mode, int'((v >> (ob * (og - 1 - k))) & ((64'd1 << ob) - 64'd1)));
        else
          c.ch = PAD_CHAR;
        c.lst = lst && (k == total - 1);
        char_q.push_back(c);
      end
      grp_bits = 40'd0;
      grp_cnt = 3'd0;
    end
  endtask

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0 || pending_q.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        drv_item = pending_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= drv_item.data;
        in_tlast <= drv_item.lst;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // monitor: checks characters, predicts from accepted bytes, drives out_tready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (char_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected char: got %h last %b", out_tdata, out_tlast);
        end else begin
          want = char_q.pop_front();
          if (out_tdata !== want.ch || out_tlast !== want.lst) begin
            mismatches++;
            if (mismatches <= 10)
              $display("char mismatch: exp %h last %b, got %h last %b",
                       want.ch, want.lst, out_tdata, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) encode_byte(in_tdata, in_tlast);
      if (stall_phase == 6'd0) begin
        case ($urandom_range(0, 3))
          0: stall_pat <= 16'hFFFF;
          1: stall_pat <= 16'($urandom);
          2: stall_pat <= 16'h5555;
          default: stall_pat <= {8'hFF, 8'($urandom_range(0, 255))};
        endcase
      end
      stall_phase <= stall_phase + 6'd1;
      out_tready <= stall_pat[stall_phase[3:0]];
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (pending_q.size() != 0 || in_tvalid || char_q.size() != 0) @(negedge clk);
  endtask

  task automatic apply_cfg(input logic [2:0] mode, input logic pad);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_ALPHABET;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_addr <= CFG_PADDING;
    cfg_wdata <= {2'b00, pad};
    @(posedge clk);
    cfg_we <= 1'b0;
    enc_mode = mode;
    enc_pad = pad;
    @(negedge clk);
  endtask

  task automatic send(input logic [7:0] b, input logic lst);
    msg_byte_t m;
    m.data = b;
    m.lst = lst;
    pending_q.push_back(m);
  endtask

  initial begin
    int ph, len, k, sent, mode_sel;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    apply_cfg(MODE_B64, 1'b1);
    send(8'hFF, 1'b0); send(8'hFF, 1'b0); send(8'hFF, 1'b0);
    send(8'hFB, 1'b0); send(8'hEF, 1'b0); send(8'hBE, 1'b0);
    send(8'h00, 1'b1);
    send(8'h00, 1'b0); send(8'h80, 1'b1);
    apply_cfg(MODE_B64URL, 1'b0);
    send(8'hFB, 1'b0); send(8'hEF, 1'b0); send(8'hBE, 1'b1);
    apply_cfg(MODE_B32, 1'b1);
    send(8'h00, 1'b0); send(8'hFF, 1'b0); send(8'h00, 1'b0); send(8'hFF, 1'b0);
    send(8'h00, 1'b0);
    send(8'h01, 1'b0); send(8'h23, 1'b0); send(8'h45, 1'b0); send(8'h67, 1'b1);
    apply_cfg(MODE_B32HEX, 1'b0);
    send(8'hA5, 1'b1);
    apply_cfg(MODE_B16, 1'b1);
    send(8'h3C, 1'b1);
    apply_cfg(MODE_SPARE_HI, 1'b1);
    send(8'hC3, 1'b1);
    // mode switch with a partial group held
    apply_cfg(MODE_B32, 1'b0);
    send(8'h12, 1'b0); send(8'h34, 1'b0);
    apply_cfg(MODE_B64, 1'b1);
    send(8'h56, 1'b1);

    // random messages, mostly closed, some left open across a mode switch
    for (ph = 0; ph < 10; ph++) begin
      mode_sel = (ph < 8) ? ph : $urandom_range(0, 7);
      apply_cfg(3'(mode_sel), 1'($urandom_range(0, 1)));
      sent = 0;
      while (sent < 20) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 7);
        for (k = 0; k < len; k++)
          send(8'($urandom_range(0, 255)), (k == len - 1) && ($urandom_range(0, 5) != 0));
        sent += len;
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && char_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/bnse_pkg.sv
sv/bnse_front.sv
sv/bnse_queue.sv
sv/bnse_back.sv
sv/base_n_stream_encoder_core.sv
verif/tb_top.sv
